// ===== rtl/core/ste_pkg.sv =====
// Shared sizes, operation codes and result codes of the sorted table engine.
`default_nettype none

package ste_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 6;
  localparam int COUNT_W     = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_table_engine.sv =====
// Sorted table engine: ordered table of signed values in one synchronous RAM.
// Find or miss: one upward pass, one entry per cycle.
// Delete hit: scan up to the match, then move the tail down by one.
// Insert: one downward pass from the top.
// Full table, empty table or unused code: straight to the result. One item in work at a time;
// the next item is taken while a finished result waits in the output register.
// Reset empties the table (count to zero); RAM contents are not cleared.
`default_nettype none

module sorted_table_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  operation,
  input  wire logic signed [31:0] value,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [2:0]       status,
  output logic [5:0]       position,
  output logic [6:0]       entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_PLACE,
    S_RESULT
  } state_t;

  state_t state;

  logic [ste_pkg::VALUE_WIDTH-1:0] mem [ste_pkg::CAPACITY];
  logic [ste_pkg::VALUE_WIDTH-1:0] rd_data;
  logic [ste_pkg::IDX_W-1:0]       rd_addr;
  logic                            wr_en;
  logic [ste_pkg::IDX_W-1:0]       wr_addr;
  logic [ste_pkg::VALUE_WIDTH-1:0] wr_data;

  logic [ste_pkg::VALUE_WIDTH-1:0] key;
  ste_pkg::op_t                    op;
  logic [ste_pkg::CNT_W-1:0]       count;
  logic [ste_pkg::IDX_W-1:0]       chk_idx;
  logic                            matched;
  ste_pkg::status_t                res_status;
  logic [ste_pkg::IDX_W-1:0]       res_pos;

  logic [ste_pkg::VALUE_WIDTH-1:0] in_key;
  logic [ste_pkg::IDX_W-1:0]       cnt_last;
  logic                            at_last;
  logic                            data_lt;
  logic                            data_eq;
  logic                            accept;

  assign in_key   = value[ste_pkg::VALUE_WIDTH-1:0];
  assign cnt_last = ste_pkg::IDX_W'(count - ste_pkg::CNT_W'(1));
  assign at_last  = (chk_idx == cnt_last);
  assign data_lt  = $signed(rd_data) < $signed(key);
  assign data_eq  = (rd_data == key);
  assign req_stall = (state != S_IDLE);
  assign accept   = req_valid && !req_stall;

  // read address runs one entry ahead of the entry being checked
  always_comb begin
    case (state)
      S_IDLE: begin
        rd_addr = (ste_pkg::op_t'(operation) == ste_pkg::OP_INSERT) ? cnt_last : '0;
      end
      S_UP:    rd_addr = chk_idx + ste_pkg::IDX_W'(1);
      S_DOWN:  rd_addr = chk_idx - ste_pkg::IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  // writes trail the reads, so a read never meets a pending write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key;
    case (state)
      S_IDLE: begin
        if (accept && ste_pkg::op_t'(operation) == ste_pkg::OP_INSERT && count == '0) begin
          wr_en   = 1'b1;
          wr_data = in_key;
        end
      end
      S_UP: begin
        if (matched) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx - ste_pkg::IDX_W'(1);
          wr_data = rd_data;
        end
      end
      S_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = chk_idx + ste_pkg::IDX_W'(1);
        wr_data = data_lt ? key : rd_data;
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
      matched   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_RESULT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            key     <= in_key;
            op      <= ste_pkg::op_t'(operation);
            matched <= 1'b0;
            res_pos <= '0;
            case (ste_pkg::op_t'(operation))
              ste_pkg::OP_INSERT: begin
                if (count == ste_pkg::CNT_W'(ste_pkg::CAPACITY)) begin
                  res_status <= ste_pkg::ST_FULL;
                  state      <= S_RESULT;
                end else if (count == '0) begin
                  res_status <= ste_pkg::ST_INSERTED;
                  count      <= ste_pkg::CNT_W'(1);
                  state      <= S_RESULT;
                end else begin
                  chk_idx <= cnt_last;
                  state   <= S_DOWN;
                end
              end
              ste_pkg::OP_FIND, ste_pkg::OP_DELETE: begin
                if (count == '0) begin
                  res_status <= ste_pkg::ST_NOT_FOUND;
                  state      <= S_RESULT;
                end else begin
                  chk_idx <= '0;
                  state   <= S_UP;
                end
              end
              default: begin
                res_status <= ste_pkg::ST_NOT_FOUND;
                state      <= S_RESULT;
              end
            endcase
          end
        end
        S_UP: begin
          if (matched) begin
            // delete: moving the tail down by one
            if (at_last) begin
              res_status <= ste_pkg::ST_DELETED;
              count      <= count - ste_pkg::CNT_W'(1);
              state      <= S_RESULT;
            end else begin
              chk_idx <= chk_idx + ste_pkg::IDX_W'(1);
            end
          end else if (data_lt) begin
            if (at_last) begin
              res_status <= ste_pkg::ST_NOT_FOUND;
              state      <= S_RESULT;
            end else begin
              chk_idx <= chk_idx + ste_pkg::IDX_W'(1);
            end
          end else if (data_eq) begin
            res_pos <= chk_idx;
            if (op == ste_pkg::OP_FIND) begin
              res_status <= ste_pkg::ST_FOUND;
              state      <= S_RESULT;
            end else if (at_last) begin
              res_status <= ste_pkg::ST_DELETED;
              count      <= count - ste_pkg::CNT_W'(1);
              state      <= S_RESULT;
            end else begin
              matched <= 1'b1;
              chk_idx <= chk_idx + ste_pkg::IDX_W'(1);
            end
          end else begin
            res_status <= ste_pkg::ST_NOT_FOUND;
            state      <= S_RESULT;
          end
        end
        S_DOWN: begin
          if (data_lt) begin
            res_status <= ste_pkg::ST_INSERTED;
            res_pos    <= chk_idx + ste_pkg::IDX_W'(1);
            count      <= count + ste_pkg::CNT_W'(1);
            state      <= S_RESULT;
          end else if (chk_idx == '0) begin
            state <= S_PLACE;
          end else begin
            chk_idx <= chk_idx - ste_pkg::IDX_W'(1);
          end
        end
        S_PLACE: begin
          res_status <= ste_pkg::ST_INSERTED;
          res_pos    <= '0;
          count      <= count + ste_pkg::CNT_W'(1);
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            position    <= ste_pkg::POS_W'(res_pos);
            entry_count <= ste_pkg::COUNT_W'(count);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  function automatic logic COUNT_LT_POS_OK(logic [5:0] pos, logic [6:0] cnt);
    return {1'b0, pos} < cnt;
  endfunction

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ste_pkg::CNT_W'(ste_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP || state == S_DOWN) |-> (ste_pkg::CNT_W'(chk_idx) < count))
    else $error("scan index beyond used entries");

  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ste_pkg::ST_NOT_FOUND || status == ste_pkg::ST_FULL))
      |-> (position == '0))
    else $error("nonzero position on miss or full");

  a_insert_position: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ste_pkg::ST_INSERTED) |-> (COUNT_LT_POS_OK(position, entry_count)))
    else $error("inserted position not below entry count");

endmodule

`default_nettype wire
